@@ sv/nrmc_pkg.sv @@
// Package with the shared types and constants of the RMC position extractor.
`timescale 1ns / 1ps

package nrmc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_V      = 8'h56;

  localparam logic [3:0] MIN_COMMAS    = 4'd5;
  localparam logic [3:0] MAX_COMMAS    = 4'd15;
  localparam logic [3:0] STATUS_COMMA  = 4'd2;
  localparam logic [3:0] LAT_COMMA     = 4'd3;
  localparam logic [3:0] LON_COMMA     = 4'd5;

  localparam logic [1:0] KIND_LAT    = 2'd0;
  localparam logic [1:0] KIND_LON    = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_RD,
    ST_LD,
    ST_REP
  } nrmc_state_t;

endpackage

@@ sv/nrmc_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module nrmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 22
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/nmea_rmc_position_extractor.sv @@
// Top level of the RMC position extractor: sentence tracking, field RAM and drain.
`timescale 1ns / 1ps

// Takes one GPS byte per item and follows each sentence from '$' to a carriage
// return or MAX_SENTENCE bytes. Latitude and longitude characters (up to
// FIELD_CHARS each) are written into one field RAM as they arrive; a byte is
// taken every cycle while a sentence runs. When a sentence ends, in_stall
// rises while the block drains: each character item needs a RAM read, then
// the load of the output register, and the report comes after the last
// character; out_stall holds the drain while the output register is full.
// Only the report goes out when there is no valid fix, and it is always the
// item marked with last.
module nmea_rmc_position_extractor #(
  parameter int MAX_SENTENCE = 127,
  parameter int FIELD_CHARS  = 11
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] item_kind,
  output logic [7:0] char_value,
  output logic       fix_valid,
  output logic [7:0] status_char,
  output logic       last
);

  localparam int SL_W  = $clog2(MAX_SENTENCE + 1);
  localparam int LEN_W = $clog2(FIELD_CHARS + 1);
  localparam int DEPTH = 2 * FIELD_CHARS;
  localparam int AW    = $clog2(DEPTH);

  nrmc_pkg::nrmc_state_t state, state_next;

  logic             hunting, hunting_next;
  logic [SL_W-1:0]  sentence_length, sentence_length_next;
  logic [3:0]       comma_count, comma_count_next;
  logic [7:0]       captured_status, captured_status_next;
  logic             status_pending, status_pending_next;
  logic             third_is_r, third_is_r_next;
  logic [LEN_W-1:0] latitude_length, latitude_length_next;
  logic [LEN_W-1:0] longitude_length, longitude_length_next;
  logic             fix, fix_next;
  logic             lon_phase, lon_phase_next;
  logic [LEN_W-1:0] rd_index, rd_index_next;

  logic             out_valid_next;
  logic [1:0]       item_kind_next;
  logic [7:0]       char_value_next;
  logic             fix_valid_next;
  logic [7:0]       status_char_next;
  logic             last_next;

  logic             in_take;
  logic             out_free;
  logic             sentence_end;
  logic             fix_now;
  logic [LEN_W-1:0] index_inc;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  assign in_stall = (state != nrmc_pkg::ST_RUN);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign index_inc = rd_index + LEN_W'(1);

  // Latitude lives in the lower half of the RAM, longitude in the upper half.
  assign ram_raddr = lon_phase ? (AW'(FIELD_CHARS) + AW'(rd_index)) : AW'(rd_index);

  nrmc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_field_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nrmc_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hunting          <= 1'b1;
      sentence_length  <= '0;
      comma_count      <= '0;
      captured_status  <= nrmc_pkg::CH_V;
      status_pending   <= 1'b0;
      third_is_r       <= 1'b0;
      latitude_length  <= '0;
      longitude_length <= '0;
      out_valid        <= 1'b0;
    end else begin
      hunting          <= hunting_next;
      sentence_length  <= sentence_length_next;
      comma_count      <= comma_count_next;
      captured_status  <= captured_status_next;
      status_pending   <= status_pending_next;
      third_is_r       <= third_is_r_next;
      latitude_length  <= latitude_length_next;
      longitude_length <= longitude_length_next;
      out_valid        <= out_valid_next;
    end
    fix         <= fix_next;
    lon_phase   <= lon_phase_next;
    rd_index    <= rd_index_next;
    item_kind   <= item_kind_next;
    char_value  <= char_value_next;
    fix_valid   <= fix_valid_next;
    status_char <= status_char_next;
    last        <= last_next;
  end

  always_comb begin
    state_next            = state;
    hunting_next          = hunting;
    sentence_length_next  = sentence_length;
    comma_count_next      = comma_count;
    captured_status_next  = captured_status;
    status_pending_next   = status_pending;
    third_is_r_next       = third_is_r;
    latitude_length_next  = latitude_length;
    longitude_length_next = longitude_length;
    fix_next              = fix;
    lon_phase_next        = lon_phase;
    rd_index_next         = rd_index;
    out_valid_next        = out_valid && out_stall;
    item_kind_next        = item_kind;
    char_value_next       = char_value;
    fix_valid_next        = fix_valid;
    status_char_next      = status_char;
    last_next             = last;
    sentence_end          = 1'b0;
    fix_now               = 1'b0;
    ram_we                = 1'b0;
    ram_waddr             = '0;

    case (state)
      nrmc_pkg::ST_RUN: begin
        if (in_take) begin
          if (hunting) begin
            if (rx_byte == nrmc_pkg::CH_DOLLAR) begin
              hunting_next = 1'b0;
            end
          end else if (rx_byte == nrmc_pkg::CH_CR) begin
            sentence_end = 1'b1;
          end else begin
            if (status_pending) begin
              captured_status_next = rx_byte;
              status_pending_next  = 1'b0;
            end
            if (sentence_length == SL_W'(2) && rx_byte == nrmc_pkg::CH_R) begin
              third_is_r_next = 1'b1;
            end
            if (rx_byte == nrmc_pkg::CH_COMMA) begin
              if (comma_count < nrmc_pkg::MAX_COMMAS) begin
                comma_count_next = comma_count + 4'd1;
              end
              if (comma_count_next == nrmc_pkg::STATUS_COMMA) begin
                status_pending_next = 1'b1;
              end
            end else if (comma_count == nrmc_pkg::LAT_COMMA) begin
              if (latitude_length < LEN_W'(FIELD_CHARS)) begin
                ram_we               = 1'b1;
                ram_waddr            = AW'(latitude_length);
                latitude_length_next = latitude_length + LEN_W'(1);
              end
            end else if (comma_count == nrmc_pkg::LON_COMMA) begin
              if (longitude_length < LEN_W'(FIELD_CHARS)) begin
                ram_we                = 1'b1;
                ram_waddr             = AW'(FIELD_CHARS) + AW'(longitude_length);
                longitude_length_next = longitude_length + LEN_W'(1);
              end
            end
            sentence_length_next = sentence_length + SL_W'(1);
            if (sentence_length_next >= SL_W'(MAX_SENTENCE)) begin
              sentence_end = 1'b1;
            end
          end

          if (sentence_end) begin
            fix_now = (captured_status_next == nrmc_pkg::CH_A) && third_is_r_next &&
                      (comma_count_next >= nrmc_pkg::MIN_COMMAS);
            fix_next      = fix_now;
            rd_index_next = '0;
            if (fix_now && latitude_length_next != '0) begin
              lon_phase_next = 1'b0;
              state_next     = nrmc_pkg::ST_RD;
            end else if (fix_now && longitude_length_next != '0) begin
              lon_phase_next = 1'b1;
              state_next     = nrmc_pkg::ST_RD;
            end else begin
              state_next = nrmc_pkg::ST_REP;
            end
          end
        end
      end

      nrmc_pkg::ST_RD: begin
        state_next = nrmc_pkg::ST_LD;
      end

      nrmc_pkg::ST_LD: begin
        // The read address is held here, so the RAM data stays put while the
        // output register is still occupied.
        if (out_free) begin
          out_valid_next   = 1'b1;
          item_kind_next   = lon_phase ? nrmc_pkg::KIND_LON : nrmc_pkg::KIND_LAT;
          char_value_next  = ram_rdata;
          fix_valid_next   = 1'b0;
          status_char_next = '0;
          last_next        = 1'b0;
          if (!lon_phase && index_inc < latitude_length) begin
            rd_index_next = index_inc;
            state_next    = nrmc_pkg::ST_RD;
          end else if (!lon_phase && longitude_length != '0) begin
            rd_index_next  = '0;
            lon_phase_next = 1'b1;
            state_next     = nrmc_pkg::ST_RD;
          end else if (lon_phase && index_inc < longitude_length) begin
            rd_index_next = index_inc;
            state_next    = nrmc_pkg::ST_RD;
          end else begin
            state_next = nrmc_pkg::ST_REP;
          end
        end
      end

      nrmc_pkg::ST_REP: begin
        if (out_free) begin
          out_valid_next        = 1'b1;
          item_kind_next        = nrmc_pkg::KIND_REPORT;
          char_value_next       = '0;
          fix_valid_next        = fix;
          status_char_next      = captured_status;
          last_next             = 1'b1;
          hunting_next          = 1'b1;
          sentence_length_next  = '0;
          comma_count_next      = '0;
          captured_status_next  = nrmc_pkg::CH_V;
          status_pending_next   = 1'b0;
          third_is_r_next       = 1'b0;
          latitude_length_next  = '0;
          longitude_length_next = '0;
          state_next            = nrmc_pkg::ST_RUN;
        end
      end

      default: begin
        state_next = nrmc_pkg::ST_RUN;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_last_is_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (item_kind == nrmc_pkg::KIND_REPORT)))
    else $error("last does not mark exactly the report item");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == nrmc_pkg::ST_LD) |->
      (lon_phase ? (rd_index < longitude_length) : (rd_index < latitude_length)))
    else $error("field RAM read beyond the captured length");

  a_chars_need_fix: assert property (@(posedge clk) disable iff (rst)
    (state == nrmc_pkg::ST_RD || state == nrmc_pkg::ST_LD) |-> fix)
    else $error("character drain started without a valid fix");

  a_report_rearms: assert property (@(posedge clk) disable iff (rst)
    (state == nrmc_pkg::ST_REP && out_free) |=> (hunting && state == nrmc_pkg::ST_RUN))
    else $error("block did not return to hunting after the report");
`endif

endmodule
